// ----- sv/snte_pkg.sv -----
// snte_pkg: widths, codes and the character map of the nibble text encoder
// no dependencies; imported by the channel interfaces and the top level
`default_nettype none

package snte_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned NIB_W  = 4;
    localparam int unsigned BYTE_W = 2 * NIB_W;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [NIB_W-1:0]  nibble_t;
    typedef logic [BYTE_W-1:0] code_byte_t;

    localparam char_t   FIRST_CODE = 8'd32;
    localparam char_t   LAST_CODE  = 8'd127;
    localparam nibble_t SHIFT_BASE = 4'd12;
    localparam nibble_t PAD_NIBBLE = 4'd15;

    typedef struct packed {
        logic       alpha;
        logic [1:0] row;
        nibble_t    col;
    } map_entry_t;

    // entry = alphabet, row, column
    localparam logic [6:0] CHAR_MAP [96] = '{
        7'h31, 7'h41, 7'h20, 7'h43, 7'h00, 7'h45, 7'h46, 7'h10,
        7'h5A, 7'h5B, 7'h44, 7'h0A, 7'h3B, 7'h0B, 7'h49, 7'h7A,
        7'h00, 7'h01, 7'h02, 7'h03, 7'h04, 7'h05, 7'h06, 7'h07,
        7'h08, 7'h09, 7'h7B, 7'h4A, 7'h6A, 7'h4B, 7'h6B, 7'h48,
        7'h50, 7'h11, 7'h12, 7'h13, 7'h14, 7'h15, 7'h16, 7'h17,
        7'h18, 7'h19, 7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26,
        7'h27, 7'h28, 7'h29, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h1A, 7'h60, 7'h1B, 7'h47, 7'h3A,
        7'h70, 7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57,
        7'h58, 7'h59, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66,
        7'h67, 7'h68, 7'h69, 7'h72, 7'h73, 7'h74, 7'h75, 7'h76,
        7'h77, 7'h78, 7'h79, 7'h2A, 7'h40, 7'h2B, 7'h71, 7'h30
    };

    // index is character minus FIRST_CODE, only meaningful below 96
    function automatic map_entry_t map_lookup(input logic [6:0] idx);
        map_entry_t e;
        e = map_entry_t'(CHAR_MAP[idx]);
        return e;
    endfunction

endpackage

`default_nettype wire

// ----- sv/snte_char_if.sv -----
// snte_char_if: valid/ready channel carrying one character beat
// depends on snte_pkg
`default_nettype none

interface snte_char_if;
    import snte_pkg::*;

    logic  valid;
    logic  ready;
    char_t ascii_char;
    logic  message_end;

    modport source (output valid, output ascii_char, output message_end, input ready);
    modport sink   (input valid, input ascii_char, input message_end, output ready);
endinterface

`default_nettype wire

// ----- sv/snte_code_if.sv -----
// snte_code_if: valid/ready channel carrying one packed code byte beat
// depends on snte_pkg
`default_nettype none

interface snte_code_if;
    import snte_pkg::*;

    logic       valid;
    logic       ready;
    code_byte_t code_byte;
    logic       run_last;
    logic       message_done;
    logic       bad_char;

    modport source (output valid, output code_byte, output run_last, output message_done,
                    output bad_char, input ready);
    modport sink   (input valid, input code_byte, input run_last, input message_done,
                    input bad_char, output ready);
endinterface

`default_nettype wire

// ----- sv/shift_nibble_text_encoder_top.sv -----
// shift_nibble_text_encoder_top: character to shift-nibble code byte encoder
// depends on snte_pkg, snte_char_if, snte_code_if
//
//   channel | dir | payload                                      | beat
//   chars   | in  | ascii_char[7:0], message_end                 | one character
//   codes   | out | code_byte[7:0], run_last, message_done,      | one packed byte
//           |     | bad_char                                     |
//
// a character beat lands in the input register, is encoded combinationally and
// loads the result register; a character that gives two bytes holds the result
// register until both have left through the single-byte output port
// chars.ready stays high while the input register is empty or drains this cycle,
// so a new character is taken while a finished byte still waits on codes
// reset (rst_n low, asynchronous) empties both registers and clears the
// alphabet, row and pending-nibble state
`default_nettype none

module shift_nibble_text_encoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    snte_char_if.sink        chars,
    snte_code_if.source      codes
);
    import snte_pkg::*;

    // input register
    logic       in_valid_reg;
    char_t      char_reg;
    logic       end_reg;

    // encoder state
    logic       alpha_reg,  alpha_next;
    logic [1:0] row_reg,    row_next;
    logic       wait_reg,   wait_next;
    nibble_t    wnib_reg,   wnib_next;

    // result register: up to two bytes of one character
    logic [1:0] res_n_reg,  res_n_next;
    logic       res_idx_reg, res_idx_next;
    code_byte_t res_b0_reg, res_b0_next;
    code_byte_t res_b1_reg, res_b1_next;
    logic       res_done_reg, res_done_next;
    logic       res_bad_reg,  res_bad_next;

    logic       res_last;
    logic       pop;
    logic       res_free;
    logic       proc;

    // encode datapath
    logic       bad;
    map_entry_t ent;
    nibble_t    seq [4];
    logic [2:0] len;
    logic [1:0] nbytes;

    // beat on the output is the last one of the current character
    assign res_last = (res_n_reg == 2'd1 && !res_idx_reg) ||
                      (res_n_reg == 2'd2 &&  res_idx_reg);
    assign pop      = codes.valid && codes.ready;
    assign res_free = (res_n_reg == 2'd0) || (pop && res_last);
    assign proc     = in_valid_reg && res_free;

    assign chars.ready = !in_valid_reg || proc;

    always_comb
    begin
        bad = (char_reg < FIRST_CODE) || (char_reg > LAST_CODE);
        ent = map_lookup(7'(char_reg - FIRST_CODE));
        seq[0] = '0;
        seq[1] = '0;
        seq[2] = '0;
        seq[3] = '0;
        len    = '0;
        // pending half byte goes first
        if (wait_reg)
        begin
            seq[0] = wnib_reg;
            len    = 3'd1;
        end
        // alphabet toggle uses the row in force before this character
        if (ent.alpha != alpha_reg)
        begin
            seq[len[1:0]] = SHIFT_BASE + nibble_t'(row_reg);
            len           = len + 3'd1;
        end
        if (ent.row != row_reg)
        begin
            seq[len[1:0]] = SHIFT_BASE + nibble_t'(ent.row);
            len           = len + 3'd1;
        end
        seq[len[1:0]] = ent.col;
        len           = len + 3'd1;
        // message end completes an odd half byte
        if (end_reg && len[0])
        begin
            seq[len[1:0]] = PAD_NIBBLE;
            len           = len + 3'd1;
        end
        nbytes = len[2:1];
    end

    // state update on each processed character
    always_comb
    begin
        alpha_next = alpha_reg;
        row_next   = row_reg;
        wait_next  = wait_reg;
        wnib_next  = wnib_reg;
        if (proc)
        begin
            if (bad || end_reg)
            begin
                alpha_next = 1'b0;
                row_next   = 2'd0;
                wait_next  = 1'b0;
                wnib_next  = '0;
            end
            else
            begin
                alpha_next = ent.alpha;
                row_next   = ent.row;
                wait_next  = len[0];
                wnib_next  = len[0] ? seq[{len[1], 1'b0}] : '0;
            end
        end
    end

    // result register load and drain
    always_comb
    begin
        res_n_next    = res_n_reg;
        res_idx_next  = res_idx_reg;
        res_b0_next   = res_b0_reg;
        res_b1_next   = res_b1_reg;
        res_done_next = res_done_reg;
        res_bad_next  = res_bad_reg;
        if (proc)
        begin
            res_idx_next  = 1'b0;
            res_n_next    = bad ? 2'd1 : nbytes;
            res_b0_next   = bad ? '0 : {seq[0], seq[1]};
            res_b1_next   = {seq[2], seq[3]};
            res_done_next = end_reg && !bad;
            res_bad_next  = bad;
        end
        else if (pop)
        begin
            if (res_last)
            begin
                res_n_next   = 2'd0;
                res_idx_next = 1'b0;
            end
            else
            begin
                res_idx_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            alpha_reg    <= 1'b0;
            row_reg      <= 2'd0;
            wait_reg     <= 1'b0;
            wnib_reg     <= '0;
            res_n_reg    <= 2'd0;
            res_idx_reg  <= 1'b0;
        end
        else
        begin
            if (chars.valid && chars.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                in_valid_reg <= 1'b0;
            end
            alpha_reg   <= alpha_next;
            row_reg     <= row_next;
            wait_reg    <= wait_next;
            wnib_reg    <= wnib_next;
            res_n_reg   <= res_n_next;
            res_idx_reg <= res_idx_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            char_reg <= chars.ascii_char;
            end_reg  <= chars.message_end;
        end
        res_b0_reg   <= res_b0_next;
        res_b1_reg   <= res_b1_next;
        res_done_reg <= res_done_next;
        res_bad_reg  <= res_bad_next;
    end

    // output beat
    assign codes.valid        = (res_n_reg != 2'd0);
    assign codes.code_byte    = res_idx_reg ? res_b1_reg : res_b0_reg;
    assign codes.run_last     = res_last;
    assign codes.message_done = res_last && res_done_reg;
    assign codes.bad_char     = res_bad_reg;

`ifndef SYNTHESIS
    // an error beat is a lone zero byte that never closes a message
    a_bad_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (codes.valid && codes.bad_char) |->
            (codes.code_byte == '0 && codes.run_last && !codes.message_done))
        else $error("bad_char beat malformed");

    // second byte of a character only exists when two were loaded
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_idx_reg |-> (res_n_reg == 2'd2))
        else $error("result index beyond loaded bytes");

    // a stalled input register holds an item until the result side frees
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !res_free) |=> (in_valid_reg && $stable(char_reg)))
        else $error("input register lost a stalled character");

    // message end always leaves the encoder in its start state
    a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && end_reg) |=> (!wait_reg && !alpha_reg && row_reg == 2'd0))
        else $error("state not cleared at message end");
`endif

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// testbench: self-checking regression of shift_nibble_text_encoder_top
// depends on snte_pkg, snte_char_if, snte_code_if and the encoder top level
// directed character table first, then random messages against a local nibble coder
`default_nettype none

module testbench;
    import snte_pkg::*;

    // run length guard, receiver hold-off length, items per phase, settle length and directed row count
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASE_ITEMS  = 376;
    localparam int TAIL_CYCLES  = 8;
    localparam int N_DIRECTED   = 25;

    // own copies of the code points used by the coder
    localparam char_t   LOW_CHAR  = 8'd32;
    localparam char_t   HIGH_CHAR = 8'd127;
    localparam nibble_t SHIFT_NIB = 4'd12;
    localparam nibble_t PAD_NIB   = 4'd15;

    // alphabet, row, column for characters 32..127; '$' shares the slot of '0'
    localparam logic [6:0] GLYPH_CODE [96] = '{
        7'h31, 7'h41, 7'h20, 7'h43, 7'h00, 7'h45, 7'h46, 7'h10,
        7'h5A, 7'h5B, 7'h44, 7'h0A, 7'h3B, 7'h0B, 7'h49, 7'h7A,
        7'h00, 7'h01, 7'h02, 7'h03, 7'h04, 7'h05, 7'h06, 7'h07,
        7'h08, 7'h09, 7'h7B, 7'h4A, 7'h6A, 7'h4B, 7'h6B, 7'h48,
        7'h50, 7'h11, 7'h12, 7'h13, 7'h14, 7'h15, 7'h16, 7'h17,
        7'h18, 7'h19, 7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26,
        7'h27, 7'h28, 7'h29, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h1A, 7'h60, 7'h1B, 7'h47, 7'h3A,
        7'h70, 7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57,
        7'h58, 7'h59, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66,
        7'h67, 7'h68, 7'h69, 7'h72, 7'h73, 7'h74, 7'h75, 7'h76,
        7'h77, 7'h78, 7'h79, 7'h2A, 7'h40, 7'h2B, 7'h71, 7'h30
    };

    // one code beat as it should appear on the output channel
    typedef struct packed {
        code_byte_t code_byte;
        logic       run_last;
        logic       message_done;
        logic       bad_char;
    } code_beat_t;

    // one row of the directed table; want is used only when typed is set
    typedef struct packed {
        char_t      ch;
        logic       fin;
        logic       typed;
        code_beat_t want;
    } char_row_t;

    logic clk;
    logic rst_n;

    snte_char_if char_ch ();
    snte_code_if code_ch ();

    shift_nibble_text_encoder_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (char_ch),
        .codes (code_ch)
    );

    // coder state, kept in step with the block at every accepted character
    logic       cur_alpha;
    logic [1:0] cur_row;
    logic       half_full;
    nibble_t    half_nib;
    code_byte_t packed_bytes [2];
    int         packed_n;
    code_beat_t fresh_beats [2];
    int         fresh_n;

    // code beats still owed by the block, oldest first
    code_beat_t expected_codes [$];
    code_beat_t want_beat;

    // idle rates in percent, and the receiver hold-off request
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    bit          hold_req;
    int          hold_left;

    int errors;
    int cycle_count;
    int chars_sent;
    int bad_sent;
    int msgs_ended;
    int beats_checked;
    int double_items;

    char_row_t directed_rows [N_DIRECTED];

    // free-running clock, period 2
    initial clk = 1'b0;
    always #1 clk = ~clk;

    function void clear_coder();
        cur_alpha = 1'b0;
        cur_row   = 2'd0;
        half_full = 1'b0;
        half_nib  = 4'd0;
    endfunction

    // append one nibble, completing a byte when a half is already waiting
    function void put_nib(input nibble_t v);
        if (!half_full) begin
            half_nib  = v;
            half_full = 1'b1;
        end
        else begin
            if (packed_n < 2)
                packed_bytes[packed_n] = {half_nib, v};
            packed_n++;
            half_full = 1'b0;
            half_nib  = 4'd0;
        end
    endfunction

    // work out the code beats of one character and advance the coder state
    function void encode_char(input char_t c, input logic fin);
        logic [6:0] glyph;
        logic       alpha;
        logic [1:0] row;
        nibble_t    col;
        packed_n = 0;
        fresh_n  = 0;
        if (c < LOW_CHAR || c > HIGH_CHAR) begin
            // out of range: single error beat, pending half dropped
            clear_coder();
            fresh_beats[0] = '{8'h00, 1'b1, 1'b0, 1'b1};
            fresh_n = 1;
            return;
        end
        glyph = GLYPH_CODE[7'(c - LOW_CHAR)];
        alpha = glyph[6];
        row   = glyph[5:4];
        col   = glyph[3:0];
        // alphabet toggle is coded from the row we are still in
        if (alpha != cur_alpha) begin
            put_nib(SHIFT_NIB + {2'b00, cur_row});
            cur_alpha = alpha;
        end
        if (row != cur_row) begin
            put_nib(SHIFT_NIB + {2'b00, row});
            cur_row = row;
        end
        put_nib(col);
        if (fin) begin
            if (half_full)
                put_nib(PAD_NIB);
            clear_coder();
        end
        fresh_n = (packed_n > 2) ? 2 : packed_n;
        for (int k = 0; k < fresh_n; k++)
            fresh_beats[k] = '{packed_bytes[k], k == fresh_n - 1,
                               (k == fresh_n - 1) && fin, 1'b0};
    endfunction

    function void check_field(input string what, input logic [7:0] want,
                              input logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        end
    endfunction

    // offer one character beat, with random gaps ahead of it, and log its beats
    task automatic send_char(input char_t ch, input logic fin, input logic typed,
                             input code_beat_t typed_beat);
        while ($urandom_range(99) < src_idle_pct) begin
            char_ch.valid      <= 1'b0;
            char_ch.ascii_char <= char_t'($urandom);
            @(posedge clk);
        end
        char_ch.valid       <= 1'b1;
        char_ch.ascii_char  <= ch;
        char_ch.message_end <= fin;
        @(posedge clk);
        while (!char_ch.ready)
            @(posedge clk);
        // accepted at this edge
        encode_char(ch, fin);
        if (typed)
            expected_codes.push_back(typed_beat);
        else
            for (int k = 0; k < fresh_n; k++)
                expected_codes.push_back(fresh_beats[k]);
        chars_sent++;
        if (ch < LOW_CHAR || ch > HIGH_CHAR)
            bad_sent++;
        else if (fin)
            msgs_ended++;
        if (fresh_n == 2)
            double_items++;
    endtask

    // sender stops offering until the block has delivered everything owed
    task automatic drain_codes();
        char_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_codes.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random ready, or a counted hold-off when one is requested
    initial begin
        code_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                code_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                code_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // output monitor: every accepted code beat against the oldest owed one
    always @(posedge clk) begin
        if (rst_n && code_ch.valid && code_ch.ready) begin
            beats_checked++;
            if (expected_codes.size() == 0) begin
                errors++;
                $display("%0t: unexpected code beat, expected none, got %h last %b done %b bad %b",
                         $time, code_ch.code_byte, code_ch.run_last,
                         code_ch.message_done, code_ch.bad_char);
            end
            else begin
                want_beat = expected_codes.pop_front();
                check_field("code_byte", want_beat.code_byte, code_ch.code_byte);
                check_field("run_last", 8'(want_beat.run_last), 8'(code_ch.run_last));
                check_field("message_done", 8'(want_beat.message_done),
                            8'(code_ch.message_done));
                check_field("bad_char", 8'(want_beat.bad_char), 8'(code_ch.bad_char));
            end
        end
    end

    // watchdog on total run length
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d beats still owed",
                     $time, cycle_count, expected_codes.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int    len;
        int    roll;
        int    phase_items;
        char_t c;
        logic  fin;

        errors        = 0;
        cycle_count   = 0;
        chars_sent    = 0;
        bad_sent      = 0;
        msgs_ended    = 0;
        beats_checked = 0;
        double_items  = 0;
        hold_req      = 1'b0;
        hold_left     = 0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        clear_coder();

        // directed rows: typed beats are read straight off the code table
        directed_rows = '{
            // after reset: space needs a row shift into row 3
            '{8'h20, 1'b1, 1'b1, '{8'hF1, 1'b1, 1'b1, 1'b0}},
            // NUL and other out-of-range bytes give the error beat
            '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},
            // DEL, top of the range
            '{8'h7F, 1'b1, 1'b1, '{8'hF0, 1'b1, 1'b1, 1'b0}},
            // dollar codes as zero, lone nibble padded
            '{8'h24, 1'b1, 1'b1, '{8'h0F, 1'b1, 1'b1, 1'b0}},
            // asterisk in the second alphabet
            '{8'h2A, 1'b1, 1'b1, '{8'hC4, 1'b1, 1'b1, 1'b0}},
            '{8'h1F, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},
            '{8'h80, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},
            '{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},
            // pending half, then alphabet and row shift: two beats
            '{8'h30, 1'b0, 1'b0, '0},
            '{8'h2F, 1'b1, 1'b0, '0},
            // pending half, row shift and pad: two beats at message end
            '{8'h30, 1'b0, 1'b0, '0},
            '{8'h41, 1'b1, 1'b0, '0},
            // a message broken by a bad byte, pending half dropped
            '{8'h48, 1'b0, 1'b0, '0},
            '{8'h69, 1'b0, 1'b0, '0},
            '{8'h2C, 1'b0, 1'b0, '0},
            '{8'h20, 1'b0, 1'b0, '0},
            '{8'h57, 1'b0, 1'b0, '0},
            '{8'h0A, 1'b0, 1'b0, '0},
            '{8'h78, 1'b0, 1'b0, '0},
            '{8'h7E, 1'b0, 1'b0, '0},
            '{8'h2A, 1'b0, 1'b0, '0},
            '{8'h24, 1'b1, 1'b0, '0},
            '{8'h7A, 1'b0, 1'b0, '0},
            '{8'h5A, 1'b0, 1'b0, '0},
            '{8'h60, 1'b1, 1'b0, '0}
        };

        // reset held low first, inputs known from the start
        rst_n               <= 1'b0;
        char_ch.valid       <= 1'b0;
        char_ch.ascii_char  <= 8'h00;
        char_ch.message_end <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with both sides always ready
        for (int i = 0; i < N_DIRECTED; i++)
            send_char(directed_rows[i].ch, directed_rows[i].fin,
                      directed_rows[i].typed, directed_rows[i].want);
        drain_codes();

        // random part in three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle_pct = 37; sink_idle_pct = 54; end
                1: begin src_idle_pct = 54; sink_idle_pct = 37; end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            // long receiver hold-off while the sender keeps offering
            if (phase < 2)
                hold_req = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                len = $urandom_range(12, 1);
                for (int k = 0; k < len; k++) begin
                    roll = $urandom_range(99);
                    if (roll < 5) begin
                        // raw noise: any byte, any end flag
                        c   = char_t'($urandom_range(255));
                        fin = 1'($urandom_range(1));
                    end
                    else if (roll < 8) begin
                        // surely out of range, low or high
                        c   = $urandom_range(1) ? char_t'($urandom_range(31))
                                                : char_t'($urandom_range(255, 128));
                        fin = 1'($urandom_range(1));
                    end
                    else begin
                        // well-formed message; now and then the end flag is missing
                        c   = char_t'($urandom_range(127, 32));
                        fin = (k == len - 1) && ($urandom_range(9) != 0);
                    end
                    send_char(c, fin, 1'b0, '0);
                    phase_items++;
                end
            end
            // sender pauses until every owed beat has come
            drain_codes();
        end

        // settle, then report
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_codes.size() != 0) begin
            errors++;
            $display("%0t: %0d code beats never arrived", $time, expected_codes.size());
        end
        $display("covered %0d characters (%0d out of range), %0d ended messages",
                 chars_sent, bad_sent, msgs_ended);
        $display("checked %0d code beats, %0d characters gave two beats, %0d errors",
                 beats_checked, double_items, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
sv/snte_pkg.sv
sv/snte_char_if.sv
sv/snte_code_if.sv
sv/shift_nibble_text_encoder_top.sv
tb/testbench.sv
